// File: src/sor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sor_pkg: shared types and constants for the spiral order reader
// Matrix limits, item layouts, the walker control group and register indexes.
// ----------------------------------------------------------------------------
package sor_pkg;

  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int DIM_W       = 5;
  localparam int EMIT_W      = $clog2(STORE_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_value;
    logic [3:0]  out_row;
    logic [3:0]  out_col;
    logic        status;
    logic        last_flag;
  } out_item_t;

  // Control from the top level to the spiral walker
  typedef struct packed {
    logic rearm;
    logic step;
  } walk_ctrl_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } walk_pos_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// File: src/sor_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sor_walker: clockwise spiral position generator
// Holds the four shrinking bounds, the heading and the current position.
// ----------------------------------------------------------------------------
module sor_walker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sor_pkg::walk_ctrl_t      ctrl,
  input  logic [sor_pkg::DIM_W-1:0] row_count,
  input  logic [sor_pkg::DIM_W-1:0] col_count,
  output sor_pkg::walk_pos_t       pos
);

  typedef enum logic [1:0] {
    HEAD_RIGHT = 2'd0,
    HEAD_DOWN  = 2'd1,
    HEAD_LEFT  = 2'd2,
    HEAD_UP    = 2'd3
  } heading_t;

  heading_t                       heading_r, heading_nxt;
  logic [sor_pkg::DIM_W-1:0]      top_r, top_nxt;
  logic [sor_pkg::DIM_W-1:0]      bottom_r, bottom_nxt;
  logic [sor_pkg::DIM_W-1:0]      left_r, left_nxt;
  logic [sor_pkg::DIM_W-1:0]      right_r, right_nxt;
  logic [sor_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [sor_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [sor_pkg::DIM_W-1:0]      row_ext, col_ext;

  assign row_ext = sor_pkg::DIM_W'(row_r);
  assign col_ext = sor_pkg::DIM_W'(col_r);

  always_comb begin
    heading_nxt = heading_r;
    top_nxt     = top_r;
    bottom_nxt  = bottom_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    if (ctrl.rearm) begin
      heading_nxt = HEAD_RIGHT;
      top_nxt     = '0;
      bottom_nxt  = row_count;
      left_nxt    = '0;
      right_nxt   = col_count;
      row_nxt     = '0;
      col_nxt     = '0;
    end else if (ctrl.step) begin
      // At the end of a side, retire that side's bound and turn clockwise
      case (heading_r)
        HEAD_RIGHT: begin
          if (col_ext + sor_pkg::DIM_W'(1) < right_r) begin
            col_nxt = col_r + sor_pkg::COL_W'(1);
          end else begin
            top_nxt     = top_r + sor_pkg::DIM_W'(1);
            heading_nxt = HEAD_DOWN;
            row_nxt     = row_r + sor_pkg::ROW_W'(1);
          end
        end
        HEAD_DOWN: begin
          if (row_ext + sor_pkg::DIM_W'(1) < bottom_r) begin
            row_nxt = row_r + sor_pkg::ROW_W'(1);
          end else begin
            right_nxt   = right_r - sor_pkg::DIM_W'(1);
            heading_nxt = HEAD_LEFT;
            col_nxt     = col_r - sor_pkg::COL_W'(1);
          end
        end
        HEAD_LEFT: begin
          if (col_ext > left_r) begin
            col_nxt = col_r - sor_pkg::COL_W'(1);
          end else begin
            bottom_nxt  = bottom_r - sor_pkg::DIM_W'(1);
            heading_nxt = HEAD_UP;
            row_nxt     = row_r - sor_pkg::ROW_W'(1);
          end
        end
        HEAD_UP: begin
          if (row_ext > top_r) begin
            row_nxt = row_r - sor_pkg::ROW_W'(1);
          end else begin
            left_nxt    = left_r + sor_pkg::DIM_W'(1);
            heading_nxt = HEAD_RIGHT;
            col_nxt     = col_r + sor_pkg::COL_W'(1);
          end
        end
        default: begin
          heading_nxt = HEAD_RIGHT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= HEAD_RIGHT;
      top_r     <= '0;
      bottom_r  <= sor_pkg::DIM_W'(1);
      left_r    <= '0;
      right_r   <= sor_pkg::DIM_W'(1);
      row_r     <= '0;
      col_r     <= '0;
    end else begin
      heading_r <= heading_nxt;
      top_r     <= top_nxt;
      bottom_r  <= bottom_nxt;
      left_r    <= left_nxt;
      right_r   <= right_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
    end
  end

  assign pos.row = row_r;
  assign pos.col = col_r;

  // The window never inverts while walking
  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r <= bottom_r) && (left_r <= right_r))
    else $error("spiral bounds crossed");

  a_rearm_home: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rearm |=> (row_r == '0) && (col_r == '0) && (heading_r == HEAD_RIGHT))
    else $error("walker not at origin after rearm");

  a_right_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (heading_r == HEAD_RIGHT) |-> (col_ext < right_r) || (right_r == '0))
    else $error("walker beyond right bound");

endmodule

// File: src/spiral_order_reader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiral_order_reader_core: matrix reorder buffer with spiral readout
// Loads a matrix row-major and reads it back in clockwise spiral order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): a load item (op 0) writes
//   the next element row-major; a fetch item (op 1) returns one result.
//   Loads give no result; extra loads after the matrix is full are dropped.
//   A fetch before the matrix is full returns status not_ready, zero fields.
//   Result channel (out_valid / out_stall / out_data): one result per fetch,
//   from an output register, valid in the cycle after the fetch is taken.
//   Throughput is one item per cycle while in_stall is low, set by the single
//   port of the element store (one write or one registered read per cycle).
//   The final spiral element carries last_flag and rearms for a new matrix.
//   Configuration (cfg_we / cfg_index / cfg_data) sets row and column counts,
//   clamped to 1..16, and rearms; write only while idle.
//   Reset: counts are 1x1, nothing loaded, output empty; store contents are
//   left undefined (no clearing pass).
//   Stall: while a result waits under out_stall, in_stall is raised and the
//   result is held.
// ----------------------------------------------------------------------------
module spiral_order_reader_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sor_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sor_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [sor_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sor_pkg::DIM_W-1:0]     cfg_data
);

  logic [sor_pkg::VALUE_WIDTH-1:0] store_mem [sor_pkg::STORE_DEPTH];

  logic [sor_pkg::DIM_W-1:0]  row_count_r, row_count_nxt;
  logic [sor_pkg::DIM_W-1:0]  col_count_r, col_count_nxt;
  logic [sor_pkg::DIM_W-1:0]  load_row_r, load_row_nxt;
  logic [sor_pkg::COL_W-1:0]  load_col_r, load_col_nxt;
  logic [sor_pkg::EMIT_W-1:0] emitted_r, emitted_nxt;
  logic [sor_pkg::EMIT_W-1:0] total_w;

  logic                            out_valid_r;
  logic [sor_pkg::VALUE_WIDTH-1:0] out_value_r;
  logic                            value_zero_r;
  logic [sor_pkg::ROW_W-1:0]       out_row_r;
  logic [sor_pkg::COL_W-1:0]       out_col_r;
  logic                            status_r;
  logic                            last_r;

  logic                     in_acc, out_acc, cfg_hit;
  logic                     is_load, is_fetch, full, fetch_ok, last_w, load_wrap;
  logic [sor_pkg::ADDR_W-1:0] load_addr, read_addr;
  sor_pkg::walk_ctrl_t      walk_ctrl;
  sor_pkg::walk_pos_t       pos;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign out_acc  = out_valid_r & ~out_stall;

  assign cfg_hit  = cfg_we && ((cfg_index == sor_pkg::REG_ROW_COUNT) ||
                               (cfg_index == sor_pkg::REG_COL_COUNT));

  assign total_w  = sor_pkg::EMIT_W'(row_count_r * col_count_r);
  assign full     = (load_row_r == row_count_r);
  assign is_load  = in_acc && (in_data.op == sor_pkg::OP_LOAD);
  assign is_fetch = in_acc && (in_data.op == sor_pkg::OP_FETCH);
  assign fetch_ok = is_fetch && full;
  assign last_w   = (emitted_r + sor_pkg::EMIT_W'(1)) >= total_w;
  assign load_wrap = (sor_pkg::DIM_W'(load_col_r) + sor_pkg::DIM_W'(1)) == col_count_r;

  assign load_addr = sor_pkg::ADDR_W'(load_row_r[sor_pkg::ROW_W-1:0]) *
                     sor_pkg::ADDR_W'(sor_pkg::MAX_COLS) + sor_pkg::ADDR_W'(load_col_r);
  assign read_addr = sor_pkg::ADDR_W'(pos.row) * sor_pkg::ADDR_W'(sor_pkg::MAX_COLS) +
                     sor_pkg::ADDR_W'(pos.col);

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (cfg_we && (cfg_index == sor_pkg::REG_ROW_COUNT)) begin
      row_count_nxt = sor_pkg::clamp_dim(cfg_data, sor_pkg::DIM_W'(sor_pkg::MAX_ROWS));
    end
    if (cfg_we && (cfg_index == sor_pkg::REG_COL_COUNT)) begin
      col_count_nxt = sor_pkg::clamp_dim(cfg_data, sor_pkg::DIM_W'(sor_pkg::MAX_COLS));
    end
  end

  always_comb begin
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    emitted_nxt  = emitted_r;
    walk_ctrl    = '0;
    if (cfg_hit || (fetch_ok && last_w)) begin
      load_row_nxt    = '0;
      load_col_nxt    = '0;
      emitted_nxt     = '0;
      walk_ctrl.rearm = 1'b1;
    end else if (fetch_ok) begin
      emitted_nxt    = emitted_r + sor_pkg::EMIT_W'(1);
      walk_ctrl.step = 1'b1;
    end else if (is_load && !full) begin
      if (load_wrap) begin
        load_col_nxt = '0;
        load_row_nxt = load_row_r + sor_pkg::DIM_W'(1);
      end else begin
        load_col_nxt = load_col_r + sor_pkg::COL_W'(1);
      end
    end
  end

  sor_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (walk_ctrl),
    .row_count (row_count_nxt),
    .col_count (col_count_nxt),
    .pos       (pos)
  );

  // Element store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (is_load && !full) begin
      store_mem[load_addr] <= in_data.element_value;
    end
    if (fetch_ok) begin
      out_value_r <= store_mem[read_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (is_fetch) begin
      value_zero_r <= !full;
      out_row_r    <= full ? pos.row : '0;
      out_col_r    <= full ? pos.col : '0;
      status_r     <= full ? sor_pkg::STATUS_OK : sor_pkg::STATUS_NOT_READY;
      last_r       <= full && last_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= sor_pkg::DIM_W'(1);
      col_count_r <= sor_pkg::DIM_W'(1);
      load_row_r  <= '0;
      load_col_r  <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      emitted_r   <= emitted_nxt;
      if (is_fetch) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.out_value = value_zero_r ? '0 : out_value_r;
  assign out_data.out_row   = out_row_r;
  assign out_data.out_col   = out_col_r;
  assign out_data.status    = status_r;
  assign out_data.last_flag = last_r;

  a_emit_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    emitted_r < total_w)
    else $error("emitted count reached matrix size");

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (fetch_ok && last_w && !cfg_hit) |=> (load_row_r == '0) && (emitted_r == '0))
    else $error("block not rearmed after final element");

  a_last_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (status_r == sor_pkg::STATUS_OK))
    else $error("last flag on a not-ready result");

  a_no_emit_unloaded: assert property (@(posedge clk) disable iff (!rst_n)
    (emitted_r != '0) |-> full)
    else $error("readout under way with matrix not full");

endmodule

// File: tb/spiral_order_reader_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiral_order_reader_core_test: self-checking bench for the spiral reader
// Drives load and fetch items with random gaps and output stalls, mirrors the
// matrix store and spiral walk in a small class and checks every result.
// ----------------------------------------------------------------------------
module spiral_order_reader_core_test;

  localparam logic [sor_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = sor_pkg::CFG_IDX_W'(2);
  localparam logic [sor_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = sor_pkg::CFG_IDX_W'(3);
  localparam int WORK_TARGET = 2000;
  localparam int CALM_FROM   = 1700;

  typedef enum int unsigned {HEAD_RIGHT, HEAD_DOWN, HEAD_LEFT, HEAD_UP} heading_t;

  // Mirror of the matrix store and spiral walker; holds the results still due
  class spiral_readout_t;
    logic [31:0]         elems [sor_pkg::STORE_DEPTH];
    int unsigned         rows, cols, loaded, emitted;
    int unsigned         lo_row, hi_row, lo_col, hi_col, row_pos, col_pos;
    heading_t            heading;
    sor_pkg::out_item_t  due_q[$];
    int                  errors, ok_count, not_ready_count, last_count;

    function new();
      rows = 1;
      cols = 1;
      rearm();
    endfunction

    function void rearm();
      loaded  = 0;
      emitted = 0;
      lo_row  = 0;
      hi_row  = rows;
      lo_col  = 0;
      hi_col  = cols;
      heading = HEAD_RIGHT;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int unsigned fit_dim(logic [sor_pkg::DIM_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void set_reg(logic [sor_pkg::CFG_IDX_W-1:0] idx, logic [sor_pkg::DIM_W-1:0] v);
      if (idx == sor_pkg::REG_ROW_COUNT) rows = fit_dim(v, sor_pkg::MAX_ROWS);
      else if (idx == sor_pkg::REG_COL_COUNT) cols = fit_dim(v, sor_pkg::MAX_COLS);
      else return;
      rearm();
    endfunction

    function void walk();
      case (heading)
        HEAD_RIGHT: begin
          if (col_pos + 1 < hi_col) col_pos++;
          else begin
            lo_row++;
            heading = HEAD_DOWN;
            row_pos++;
          end
        end
        HEAD_DOWN: begin
          if (row_pos + 1 < hi_row) row_pos++;
          else begin
            hi_col--;
            heading = HEAD_LEFT;
            col_pos--;
          end
        end
        HEAD_LEFT: begin
          if (col_pos > lo_col) col_pos--;
          else begin
            hi_row--;
            heading = HEAD_UP;
            row_pos--;
          end
        end
        default: begin
          if (row_pos > lo_row) row_pos--;
          else begin
            lo_col++;
            heading = HEAD_RIGHT;
            col_pos++;
          end
        end
      endcase
      row_pos &= 63;
      col_pos &= 63;
    endfunction

    // Returns 1 when the item does real work (a stored load or any fetch)
    function bit take_item(sor_pkg::in_item_t it);
      int unsigned        total;
      sor_pkg::out_item_t e;
      total = rows * cols;
      if (it.op == sor_pkg::OP_LOAD) begin
        if (loaded >= total) return 0;
        elems[(loaded / cols) * sor_pkg::MAX_COLS + (loaded % cols)] = it.element_value;
        loaded++;
        return 1;
      end
      e = '0;
      if (loaded < total) begin
        e.status = sor_pkg::STATUS_NOT_READY;
        not_ready_count++;
      end else begin
        e.out_value = elems[row_pos * sor_pkg::MAX_COLS + col_pos];
        e.out_row   = row_pos[3:0];
        e.out_col   = col_pos[3:0];
        e.status    = sor_pkg::STATUS_OK;
        ok_count++;
        emitted++;
        if (emitted >= total) begin
          e.last_flag = 1'b1;
          last_count++;
          rearm();
        end else begin
          walk();
        end
      end
      due_q = {due_q, e};
      return 1;
    endfunction

    function void diff(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      end
    endfunction

    function void compare_result(sor_pkg::out_item_t got);
      sor_pkg::out_item_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none got %h", $time, got);
        return;
      end
      want = due_q.pop_front();
      diff("out_value", want.out_value, got.out_value);
      diff("out_row", want.out_row, got.out_row);
      diff("out_col", want.out_col, got.out_col);
      diff("status", want.status, got.status);
      diff("last_flag", want.last_flag, got.last_flag);
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  sor_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_stall;
  sor_pkg::out_item_t            out_data;
  logic                          cfg_we;
  logic [sor_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sor_pkg::DIM_W-1:0]     cfg_data;

  spiral_readout_t books;
  int              work_items;
  int              reg_writes;
  bit              calm;
  int              stall_left;

  spiral_order_reader_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver stalls come in bursts; none once the run has gone calm
  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!calm && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 8);
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) books.compare_result(out_data);
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [sor_pkg::DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return sor_pkg::DIM_W'($urandom_range(17, 31));
      2: return sor_pkg::DIM_W'(16);
      3: return sor_pkg::DIM_W'(1);
      default: return sor_pkg::DIM_W'($urandom_range(1, 5));
    endcase
  endfunction

  // Entered and left just after a falling edge
  task automatic send_item(sor_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (books.take_item(it)) work_items++;
    @(negedge clk);
  endtask

  task automatic do_load(logic [31:0] v);
    sor_pkg::in_item_t it;
    it.op            = sor_pkg::OP_LOAD;
    it.element_value = v;
    send_item(it);
  endtask

  task automatic do_fetch();
    sor_pkg::in_item_t it;
    it.op            = sor_pkg::OP_FETCH;
    it.element_value = $urandom;
    send_item(it);
  endtask

  // Stop sending and let every due result and any trailing work come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (books.pending() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [sor_pkg::CFG_IDX_W-1:0] idx, logic [sor_pkg::DIM_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    books.set_reg(idx, v);
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic reconfigure();
    drain();
    if ($urandom_range(0, 9) == 0) write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                                             sor_pkg::DIM_W'($urandom));
    case ($urandom_range(0, 3))
      0: write_reg(sor_pkg::REG_ROW_COUNT, pick_dim());
      1: write_reg(sor_pkg::REG_COL_COUNT, pick_dim());
      default: begin
        write_reg(sor_pkg::REG_ROW_COUNT, pick_dim());
        write_reg(sor_pkg::REG_COL_COUNT, pick_dim());
      end
    endcase
  endtask

  // One matrix: mostly clean load then readout, sometimes cut short
  task automatic run_matrix();
    int total;
    int kind;
    total = books.rows * books.cols;
    kind  = $urandom_range(0, 9);
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 15) == 0) do_fetch();
      if (kind == 0 && i == total / 2) return;
      do_load(rand_value());
    end
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 15) == 0) do_load(rand_value());
      if (kind == 1 && i > 0 && i == total / 2) return;
      do_fetch();
    end
    if ($urandom_range(0, 3) == 0) do_fetch();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    work_items = 0;
    reg_writes = 0;
    calm       = 1'b0;
    stall_left = 0;
    books      = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 1x1 after reset: early fetch, load, dropped load, readout, fetch after rearm
    do_fetch();
    do_load(32'h8000_0000);
    do_load(32'h7fff_ffff);
    do_fetch();
    do_fetch();

    drain();
    write_reg(REG_SPARE_2, sor_pkg::DIM_W'(31));
    write_reg(REG_SPARE_3, sor_pkg::DIM_W'(0));
    write_reg(sor_pkg::REG_ROW_COUNT, sor_pkg::DIM_W'(2));
    write_reg(sor_pkg::REG_COL_COUNT, sor_pkg::DIM_W'(2));
    do_load(32'hffff_ffff);
    do_fetch();
    do_load(32'h0);
    do_load(32'h7fff_ffff);
    do_load(32'h8000_0000);
    repeat (4) do_fetch();

    // Clamped extremes: tall column, wide row, then the full matrix
    drain();
    write_reg(sor_pkg::REG_ROW_COUNT, sor_pkg::DIM_W'(31));
    write_reg(sor_pkg::REG_COL_COUNT, sor_pkg::DIM_W'(0));
    run_matrix();
    drain();
    write_reg(sor_pkg::REG_ROW_COUNT, sor_pkg::DIM_W'(0));
    write_reg(sor_pkg::REG_COL_COUNT, sor_pkg::DIM_W'(17));
    run_matrix();
    drain();
    write_reg(sor_pkg::REG_ROW_COUNT, sor_pkg::DIM_W'(16));
    write_reg(sor_pkg::REG_COL_COUNT, sor_pkg::DIM_W'(16));
    run_matrix();

    while (work_items < WORK_TARGET) begin
      calm = (work_items >= CALM_FROM);
      reconfigure();
      run_matrix();
    end

    drain();
    repeat (10) @(negedge clk);
    $display("Ran %0d working items over %0d register writes.", work_items, reg_writes);
    $display("Saw %0d spiral elements, %0d not-ready fetches, %0d complete matrices.",
             books.ok_count, books.not_ready_count, books.last_count);
    if (books.errors == 0) begin
      $display("spiral_order_reader_core_test: clean");
    end else begin
      $display("spiral_order_reader_core_test: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still due.", books.pending());
    $display("spiral_order_reader_core_test: errors");
    $finish;
  end

endmodule

// File: sim.f
src/sor_pkg.sv
src/sor_walker.sv
src/spiral_order_reader_core.sv
tb/spiral_order_reader_core_test.sv
